FILE: hw/rtl/rdc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rdc_pkg
// Shared widths, item types, command kinds and status for the range distinct
// count unit.
// ============================================================================
package rdc_pkg;

  // Fixed field widths of the channels.
  localparam int POS_W    = 10;
  localparam int VAL_IN_W = 10;
  localparam int WIN_W    = 11;
  localparam int CNT_W    = 11;

  // Defaults for the top-level parameters.
  localparam int DEF_ARRAY_DEPTH = 1024;
  localparam int DEF_VALUE_BITS  = 10;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Request type on the input channel.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Command kinds after classification.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_BADQ  = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [POS_W-1:0]    position;
    logic [VAL_IN_W-1:0] value;
    logic [WIN_W-1:0]    left;
    logic [WIN_W-1:0]    right;
  } rdc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] distinct_count;
    logic             in_range;
  } rdc_out_t;

  // One classified command; a query carries zero-based first and end bounds.
  typedef struct packed {
    logic [1:0]          kind;
    logic [POS_W-1:0]    pos;
    logic [VAL_IN_W-1:0] value;
    logic [WIN_W-1:0]    first;
    logic [WIN_W-1:0]    stop;
  } rdc_cmd_t;

  // Status of the back end seen by the front and the top level.
  typedef struct packed {
    logic             clearing;
    logic [WIN_W-1:0] win_start;
    logic [WIN_W-1:0] win_end;
    logic [CNT_W-1:0] distinct;
  } rdc_stat_t;

endpackage

FILE: hw/rtl/rdc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rdc_front
// Accepts input items, checks bounds and turns each item into a command for
// the queue. Loads beyond the array are dropped here.
// ============================================================================
module rdc_front
  import rdc_pkg::*;
#(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
  input  logic     in_valid,
  input  rdc_in_t  in_data,
  output logic     in_stall,
  input  logic     clearing,
  input  logic     q_full,
  output logic     push,
  output rdc_cmd_t push_cmd
);

  logic accept;
  logic load_ok;
  logic query_ok;

  // No item is taken while memories are cleared or the queue is full.
  assign in_stall = clearing | q_full;
  assign accept   = in_valid & ~in_stall;

  // Bound checks against the array depth.
  assign load_ok  = 32'(in_data.position) < 32'(ARRAY_DEPTH);
  assign query_ok = (in_data.left != '0) && (in_data.left <= in_data.right) &&
                    (32'(in_data.right) <= 32'(ARRAY_DEPTH));

  // Classify the item and build its command.
  always_comb begin
    push_cmd.pos   = in_data.position;
    push_cmd.value = in_data.value;
    push_cmd.first = in_data.left - WIN_W'(1);
    push_cmd.stop  = in_data.right;
    if (in_data.req_type == REQ_LOAD) begin
      push_cmd.kind = KIND_LOAD;
    end else if (query_ok) begin
      push_cmd.kind = KIND_QUERY;
    end else begin
      push_cmd.kind = KIND_BADQ;
    end
    push = accept & ((in_data.req_type == REQ_QUERY) | load_ok);
  end

endmodule

FILE: hw/rtl/rdc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rdc_queue
// Short command queue that lets the front and the back stall independently.
// ============================================================================
module rdc_queue
  import rdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rdc_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output rdc_cmd_t pop_cmd,
  output logic     nonempty
);

  rdc_cmd_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     fill_r;
  logic [Q_AW:0]     fill_nxt;

  assign full     = fill_r == (Q_AW+1)'(Q_DEPTH);
  assign nonempty = fill_r != '0;
  assign pop_cmd  = slot_r[rd_ptr_r];

  // Fill level follows pushes and pops.
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (Q_AW+1)'(1);
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/rdc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rdc_back
// Executes commands: holds the element and count memories, slides the
// window one position per step and delivers query results.
// ============================================================================
module rdc_back
  import rdc_pkg::*;
#(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  rdc_cmd_t  q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output rdc_out_t  out_data,
  output rdc_stat_t stat
);

  localparam int ADDR_W     = $clog2(ARRAY_DEPTH);
  localparam int VALUE_SPAN = 1 << VALUE_BITS;
  localparam int CLEAR_LEN  = (ARRAY_DEPTH > VALUE_SPAN) ? ARRAY_DEPTH : VALUE_SPAN;
  localparam int CLR_W      = $clog2(CLEAR_LEN);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LD_C   = 4'd2;
  localparam logic [3:0] ST_LD_W   = 4'd3;
  localparam logic [3:0] ST_LD_C2  = 4'd4;
  localparam logic [3:0] ST_LD_W2  = 4'd5;
  localparam logic [3:0] ST_Q_STEP = 4'd6;
  localparam logic [3:0] ST_Q_C    = 4'd7;
  localparam logic [3:0] ST_Q_W    = 4'd8;
  localparam logic [3:0] ST_Q_OUT  = 4'd9;

  // Memories and their ports.
  logic [VALUE_BITS-1:0] elem_mem [ARRAY_DEPTH];
  logic [CNT_W-1:0]      cnt_mem  [VALUE_SPAN];
  logic                  elem_we;
  logic [ADDR_W-1:0]     elem_waddr;
  logic [ADDR_W-1:0]     elem_raddr;
  logic [VALUE_BITS-1:0] elem_wdata;
  logic [VALUE_BITS-1:0] elem_rd_r;
  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [VALUE_BITS-1:0] cnt_raddr;
  logic [VALUE_BITS-1:0] caddr_r;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [CNT_W-1:0]      cnt_rd_r;

  // Control and window registers.
  logic [3:0]            state_r, state_nxt;
  logic [CLR_W-1:0]      clr_r, clr_nxt;
  logic [WIN_W-1:0]      ws_r, ws_nxt;
  logic [WIN_W-1:0]      we_r, we_nxt;
  logic [CNT_W-1:0]      distinct_r, distinct_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rdc_out_t              out_data_r, out_data_nxt;

  // Per-command working registers.
  logic [WIN_W-1:0]      first_r, first_nxt;
  logic [WIN_W-1:0]      stop_r, stop_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  up_r, up_nxt;
  logic                  bad_r, bad_nxt;

  // Step selection and count update.
  logic                  step_has;
  logic                  step_up;
  logic [WIN_W-1:0]      step_pos;
  logic [WIN_W-1:0]      ws_step;
  logic [WIN_W-1:0]      we_step;
  logic [CNT_W-1:0]      cnt_upd;
  logic [CNT_W-1:0]      dist_upd;
  logic                  load_in_win;
  logic                  out_free;

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign stat.clearing  = state_r == ST_CLEAR;
  assign stat.win_start = ws_r;
  assign stat.win_end   = we_r;
  assign stat.distinct  = distinct_r;
  assign out_free       = !out_valid_r || !out_stall;

  // Memory ports with registered read data.
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_rd_r <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_raddr];
    caddr_r  <= cnt_raddr;
  end

  // Next window move: grow at the start, grow at the end, then shrink both.
  always_comb begin
    step_has = 1'b1;
    step_up  = 1'b1;
    step_pos = ws_r;
    ws_step  = ws_r;
    we_step  = we_r;
    if (ws_r > first_r) begin
      step_pos = ws_r - WIN_W'(1);
      ws_step  = ws_r - WIN_W'(1);
    end else if (we_r < stop_r) begin
      step_pos = we_r;
      we_step  = we_r + WIN_W'(1);
    end else if (ws_r < first_r) begin
      step_up  = 1'b0;
      step_pos = ws_r;
      ws_step  = ws_r + WIN_W'(1);
    end else if (we_r > stop_r) begin
      step_up  = 1'b0;
      step_pos = we_r - WIN_W'(1);
      we_step  = we_r - WIN_W'(1);
    end else begin
      step_has = 1'b0;
    end
  end

  // Count increment or decrement with the distinct total adjusted.
  always_comb begin
    cnt_upd  = cnt_rd_r;
    dist_upd = distinct_r;
    if (up_r) begin
      cnt_upd = cnt_rd_r + CNT_W'(1);
      if (cnt_rd_r == '0) begin
        dist_upd = distinct_r + CNT_W'(1);
      end
    end else if (cnt_rd_r != '0) begin
      cnt_upd = cnt_rd_r - CNT_W'(1);
      if (cnt_rd_r == CNT_W'(1)) begin
        dist_upd = distinct_r - CNT_W'(1);
      end
    end
  end

  assign load_in_win = (WIN_W'(q_cmd.pos) >= ws_r) && (WIN_W'(q_cmd.pos) < we_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    distinct_nxt  = distinct_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    first_nxt     = first_r;
    stop_nxt      = stop_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    up_nxt        = up_r;
    bad_nxt       = bad_r;
    q_pop         = 1'b0;
    elem_we       = 1'b0;
    elem_waddr    = ADDR_W'(pos_r);
    elem_wdata    = val_r;
    elem_raddr    = ADDR_W'(pos_r);
    cnt_we        = 1'b0;
    cnt_waddr     = caddr_r;
    cnt_wdata     = cnt_upd;
    cnt_raddr     = elem_rd_r;

    case (state_r)
      // Zero both memories, one address per cycle.
      ST_CLEAR: begin
        elem_we    = 32'(clr_r) < 32'(ARRAY_DEPTH);
        elem_waddr = ADDR_W'(clr_r);
        elem_wdata = '0;
        cnt_we     = 32'(clr_r) < 32'(VALUE_SPAN);
        cnt_waddr  = VALUE_BITS'(clr_r);
        cnt_wdata  = '0;
        clr_nxt    = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLEAR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take the next command from the queue.
      ST_IDLE: begin
        if (q_nonempty) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            KIND_LOAD: begin
              pos_nxt = q_cmd.pos;
              val_nxt = VALUE_BITS'(q_cmd.value);
              if (load_in_win) begin
                elem_raddr = ADDR_W'(q_cmd.pos);
                up_nxt     = 1'b0;
                state_nxt  = ST_LD_C;
              end else begin
                elem_we    = 1'b1;
                elem_waddr = ADDR_W'(q_cmd.pos);
                elem_wdata = VALUE_BITS'(q_cmd.value);
              end
            end
            KIND_QUERY: begin
              first_nxt = q_cmd.first;
              stop_nxt  = q_cmd.stop;
              bad_nxt   = 1'b0;
              state_nxt = ST_Q_STEP;
            end
            default: begin
              bad_nxt   = 1'b1;
              state_nxt = ST_Q_OUT;
            end
          endcase
        end
      end

      // Load inside the window: drop the old value, then add the new one.
      ST_LD_C: begin
        cnt_raddr = elem_rd_r;
        state_nxt = ST_LD_W;
      end
      ST_LD_W: begin
        cnt_we       = 1'b1;
        distinct_nxt = dist_upd;
        elem_we      = 1'b1;
        up_nxt       = 1'b1;
        state_nxt    = ST_LD_C2;
      end
      ST_LD_C2: begin
        cnt_raddr = val_r;
        state_nxt = ST_LD_W2;
      end
      ST_LD_W2: begin
        cnt_we       = 1'b1;
        distinct_nxt = dist_upd;
        state_nxt    = ST_IDLE;
      end

      // Issue the first window move of a query.
      ST_Q_STEP: begin
        if (step_has) begin
          elem_raddr = ADDR_W'(step_pos);
          ws_nxt     = ws_step;
          we_nxt     = we_step;
          up_nxt     = step_up;
          state_nxt  = ST_Q_C;
        end else begin
          state_nxt = ST_Q_OUT;
        end
      end

      // Element value is ready: read its count.
      ST_Q_C: begin
        cnt_raddr = elem_rd_r;
        state_nxt = ST_Q_W;
      end

      // Write the count back and issue the next move in the same cycle.
      ST_Q_W: begin
        cnt_we       = 1'b1;
        distinct_nxt = dist_upd;
        if (step_has) begin
          elem_raddr = ADDR_W'(step_pos);
          ws_nxt     = ws_step;
          we_nxt     = we_step;
          up_nxt     = step_up;
          state_nxt  = ST_Q_C;
        end else begin
          state_nxt = ST_Q_OUT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_Q_OUT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.distinct_count = bad_r ? '0 : distinct_r;
          out_data_nxt.in_range       = !bad_r;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ws_r        <= '0;
      we_r        <= '0;
      distinct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ws_r        <= ws_nxt;
      we_r        <= we_nxt;
      distinct_r  <= distinct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    first_r    <= first_nxt;
    stop_r     <= stop_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    up_r       <= up_nxt;
    bad_r      <= bad_nxt;
  end

endmodule

FILE: hw/rtl/range_distinct_count_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// range_distinct_count_unit
// Counts distinct values over a sliding window of a loadable element array.
// ============================================================================
// Usage: the input channel takes load items (req_type 0, position, value)
// and query items (req_type 1, one-based inclusive left and right). Each
// query gives exactly one item on the output channel: the number of distinct
// values in the range, or in_range 0 and a count of zero for bad bounds.
// Loads give no output item. Results leave in the order queries arrive.
// A front stage classifies items into a four-entry command queue; a back
// stage executes them with one element memory and one count memory.
// A load outside the window is only written to the element memory; a load
// inside it also updates both counts, and a bad query goes straight out.
// Each window step is an element read feeding a count read-modify-write in
// the count memory.
// After reset a clearing pass over max(ARRAY_DEPTH, 2**VALUE_BITS) addresses
// zeroes both memories; in_stall stays high during it.
// A stalled result waits in the output register; the back keeps working on
// loads and window moves until it needs that register again, and the front
// keeps filling the queue until it is full.
// ============================================================================
module range_distinct_count_unit
  import rdc_pkg::*;
#(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rdc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rdc_out_t out_data
);

  logic      push;
  rdc_cmd_t  push_cmd;
  logic      q_full;
  logic      q_pop;
  rdc_cmd_t  q_cmd;
  logic      q_nonempty;
  rdc_stat_t stat;

  // Item classification.
  rdc_front #(
    .ARRAY_DEPTH(ARRAY_DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .clearing (stat.clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  rdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .nonempty (q_nonempty)
  );

  // Window engine.
  rdc_back #(
    .ARRAY_DEPTH(ARRAY_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .stat       (stat)
  );

  // No item is taken while the memories are being cleared.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> in_stall)
    else $error("item accepted during clearing pass");

  // The window never inverts.
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    stat.win_start <= stat.win_end)
    else $error("window start beyond window end");

  // A rejected query always reports a zero count.
  a_bad_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |-> (out_data.distinct_count == '0))
    else $error("out-of-range result with nonzero count");

  // The front never pushes into a full queue.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overflow");

endmodule
